@@ hw/rtl/rxpc_pkg.sv @@
`default_nettype none

package rxpc_pkg;

	localparam int FIELD_W = 10;
	localparam int FREQ_W = 11;
	localparam int FREQ_DEPTH = 1 << FIELD_W;
	localparam int IN_TDATA_W = 56;
	localparam int OUT_TDATA_W = 24;

	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	localparam logic [FREQ_W-1:0] PAIR = FREQ_W'(2);

	typedef enum logic [2:0] {
		MV_NONE     = 3'd0,
		MV_INIT     = 3'd1,
		MV_GROW_L   = 3'd2,
		MV_GROW_R   = 3'd3,
		MV_SHRINK_L = 3'd4,
		MV_SHRINK_R = 3'd5
	} move_t;

	typedef struct packed {
		logic capture;
		logic elem_wr;
		logic win_clear;
		logic clr_step;
		logic step_start;
		logic freq_rd;
		logic update;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic  is_load;
		logic  bad;
		logic  win_empty;
		move_t move;
		logic  clr_last;
		logic  out_free;
	} sts_t;

endpackage

`default_nettype wire

@@ hw/rtl/rxpc_ctrl.sv @@
`default_nettype none

module rxpc_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          s_tvalid,
	output logic               s_tready,
	input  wire rxpc_pkg::sts_t sts,
	output rxpc_pkg::cmd_t     cmd
);

	typedef enum logic [5:0] {
		ST_CLEAR  = 6'b000001,
		ST_IDLE   = 6'b000010,
		ST_DECIDE = 6'b000100,
		ST_ELEM   = 6'b001000,
		ST_UPDATE = 6'b010000,
		ST_RESULT = 6'b100000
	} state_t;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd = '0;
		s_tready = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				cmd.clr_step = 1'b1;
				if (sts.clr_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.capture = 1'b1;
					state_d = ST_DECIDE;
				end
			end
			ST_DECIDE: begin
				if (sts.is_load) begin
					cmd.elem_wr = 1'b1;
					if (!sts.win_empty) begin
						cmd.win_clear = 1'b1;
						state_d = ST_CLEAR;
					end else begin
						state_d = ST_IDLE;
					end
				end else if (sts.bad || sts.move == rxpc_pkg::MV_NONE) begin
					state_d = ST_RESULT;
				end else begin
					cmd.step_start = 1'b1;
					state_d = ST_ELEM;
				end
			end
			ST_ELEM: begin
				cmd.freq_rd = 1'b1;
				state_d = ST_UPDATE;
			end
			ST_UPDATE: begin
				cmd.update = 1'b1;
				state_d = ST_DECIDE;
			end
			ST_RESULT: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_CLEAR;
			end
		endcase
	end

endmodule

`default_nettype wire

@@ hw/rtl/rxpc_datapath.sv @@
`default_nettype none

module rxpc_datapath #(
	parameter int ARRAY_SIZE = 1024
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic [rxpc_pkg::IN_TDATA_W-1:0]      s_tdata,
	input  wire logic                                 s_tuser,
	output logic                                      m_tvalid,
	input  wire logic                                 m_tready,
	output logic [rxpc_pkg::OUT_TDATA_W-1:0]          m_tdata,
	output logic                                      m_tuser,
	input  wire rxpc_pkg::cmd_t                       cmd,
	output rxpc_pkg::sts_t                            sts
);

	localparam int FW = rxpc_pkg::FIELD_W;
	localparam int QW = rxpc_pkg::FREQ_W;
	localparam int ELEM_DEPTH = (ARRAY_SIZE < rxpc_pkg::FREQ_DEPTH) ?
		ARRAY_SIZE : rxpc_pkg::FREQ_DEPTH;
	localparam int EAW = $clog2(ELEM_DEPTH);
	localparam int CMP_W = 32;
	localparam logic [CMP_W-1:0] ARRAY_LIM = CMP_W'(ARRAY_SIZE);
	localparam logic [FW-1:0] CLR_LAST = FW'(rxpc_pkg::FREQ_DEPTH - 1);
	localparam int PAD_W = rxpc_pkg::OUT_TDATA_W - 2 * FW;

	logic [FW-1:0] elem_mem [0:ELEM_DEPTH-1];
	logic [QW-1:0] freq_mem [0:rxpc_pkg::FREQ_DEPTH-1];

	logic          op_q;
	logic [FW-1:0] pos_q;
	logic [FW-1:0] val_q;
	logic [FW-1:0] left_q;
	logic [FW-1:0] right_q;
	logic [FW-1:0] tag_q;

	logic [FW-1:0] wl_q;
	logic [FW-1:0] wr_q;
	logic          empty_q;
	logic [FW-1:0] twice_q;
	logic [FW-1:0] clr_q;
	rxpc_pkg::move_t move_q;

	logic [FW-1:0] elem_rd_q;
	logic [QW-1:0] freq_rd_q;

	logic          out_valid_q;
	logic [FW-1:0] out_count_q;
	logic [FW-1:0] out_tag_q;
	logic          out_bad_q;

	rxpc_pkg::move_t move_d;
	logic [FW-1:0]   idx_d;
	logic            bad;
	logic            pos_ok;
	logic            step_add;
	logic [QW-1:0]   freq_new;
	logic            freq_we;
	logic [FW-1:0]   freq_wa;
	logic [QW-1:0]   freq_wd;

	assign bad = (left_q > right_q) || (CMP_W'(right_q) >= ARRAY_LIM);
	assign pos_ok = CMP_W'(pos_q) < ARRAY_LIM;

	always_comb begin
		if (empty_q) begin
			move_d = rxpc_pkg::MV_INIT;
		end else if (wl_q > left_q) begin
			move_d = rxpc_pkg::MV_GROW_L;
		end else if (wr_q < right_q) begin
			move_d = rxpc_pkg::MV_GROW_R;
		end else if (wl_q < left_q) begin
			move_d = rxpc_pkg::MV_SHRINK_L;
		end else if (wr_q > right_q) begin
			move_d = rxpc_pkg::MV_SHRINK_R;
		end else begin
			move_d = rxpc_pkg::MV_NONE;
		end
	end

	always_comb begin
		case (move_d)
			rxpc_pkg::MV_INIT:     idx_d = left_q;
			rxpc_pkg::MV_GROW_L:   idx_d = wl_q - FW'(1);
			rxpc_pkg::MV_GROW_R:   idx_d = wr_q + FW'(1);
			rxpc_pkg::MV_SHRINK_L: idx_d = wl_q;
			rxpc_pkg::MV_SHRINK_R: idx_d = wr_q;
			default:               idx_d = wl_q;
		endcase
	end

	assign step_add = (move_q == rxpc_pkg::MV_INIT) || (move_q == rxpc_pkg::MV_GROW_L) ||
		(move_q == rxpc_pkg::MV_GROW_R);

	always_comb begin
		if (step_add) begin
			freq_new = freq_rd_q + QW'(1);
		end else if (freq_rd_q == '0) begin
			freq_new = '0;
		end else begin
			freq_new = freq_rd_q - QW'(1);
		end
	end

	assign freq_we = cmd.clr_step || cmd.update;
	assign freq_wa = cmd.clr_step ? clr_q : elem_rd_q;
	assign freq_wd = cmd.clr_step ? '0 : freq_new;

	always_ff @(posedge clk) begin
		if (cmd.elem_wr && pos_ok) begin
			elem_mem[pos_q[EAW-1:0]] <= val_q;
		end
		if (cmd.step_start) begin
			elem_rd_q <= elem_mem[idx_d[EAW-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		if (freq_we) begin
			freq_mem[freq_wa] <= freq_wd;
		end
		if (cmd.freq_rd) begin
			freq_rd_q <= freq_mem[elem_rd_q];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q    <= s_tuser;
			pos_q   <= s_tdata[0*FW +: FW];
			val_q   <= s_tdata[1*FW +: FW];
			left_q  <= s_tdata[2*FW +: FW];
			right_q <= s_tdata[3*FW +: FW];
			tag_q   <= s_tdata[4*FW +: FW];
		end
		if (cmd.step_start) begin
			move_q <= move_d;
		end
		if (cmd.out_load) begin
			out_count_q <= bad ? '0 : twice_q;
			out_tag_q   <= tag_q;
			out_bad_q   <= bad;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wl_q    <= '0;
			wr_q    <= '0;
			empty_q <= 1'b1;
			twice_q <= '0;
			clr_q   <= '0;
		end else if (cmd.win_clear) begin
			wl_q    <= '0;
			wr_q    <= '0;
			empty_q <= 1'b1;
			twice_q <= '0;
			clr_q   <= '0;
		end else if (cmd.clr_step) begin
			clr_q <= clr_q + FW'(1);
		end else if (cmd.update) begin
			if (freq_rd_q == rxpc_pkg::PAIR) begin
				twice_q <= twice_q - FW'(1);
			end else if (freq_new == rxpc_pkg::PAIR) begin
				twice_q <= twice_q + FW'(1);
			end
			case (move_q)
				rxpc_pkg::MV_INIT: begin
					wl_q    <= left_q;
					wr_q    <= left_q;
					empty_q <= 1'b0;
				end
				rxpc_pkg::MV_GROW_L:   wl_q <= wl_q - FW'(1);
				rxpc_pkg::MV_GROW_R:   wr_q <= wr_q + FW'(1);
				rxpc_pkg::MV_SHRINK_L: wl_q <= wl_q + FW'(1);
				rxpc_pkg::MV_SHRINK_R: wr_q <= wr_q - FW'(1);
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_comb begin
		sts.is_load   = (op_q == rxpc_pkg::OP_LOAD);
		sts.bad       = bad;
		sts.win_empty = empty_q;
		sts.move      = move_d;
		sts.clr_last  = (clr_q == CLR_LAST);
		sts.out_free  = !out_valid_q || m_tready;
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{PAD_W{1'b0}}, out_tag_q, out_count_q};
	assign m_tuser  = out_bad_q;

endmodule

`default_nettype wire

@@ hw/rtl/range_exact_pair_count.sv @@
`default_nettype none

// Counts the distinct values that occur exactly twice in a range of a loaded
// array. A load transaction (s_tuser = 0) writes one element and gives no result;
// a query transaction (s_tuser = 1) slides an internal window one element at a
// time to [left, right] and returns the count with the query's tag. A load
// while the window holds elements also runs a frequency clearing sweep over all
// 1024 entries. A query makes M window moves (distance to the previous window,
// or right - left + 1 when the window is empty), each move being an element
// memory read, a frequency memory read and a frequency write in turn. After
// reset the block clears the whole frequency memory before taking the first
// transaction. A bad range (left > right or right >= ARRAY_SIZE) answers with
// count 0 and the flag set. The result sits in an output register, so the next
// transaction is taken while a result waits.
module range_exact_pair_count #(
	parameter int ARRAY_SIZE = 1024
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 s_tvalid,
	output logic                                      s_tready,
	// position, value, left, right, tag (10 bits each), zero pad
	input  wire logic [rxpc_pkg::IN_TDATA_W-1:0]      s_tdata,
	// op
	input  wire logic                                 s_tuser,
	output logic                                      m_tvalid,
	input  wire logic                                 m_tready,
	// pair_count, answer_tag (10 bits each), zero pad
	output logic [rxpc_pkg::OUT_TDATA_W-1:0]          m_tdata,
	// bad_range
	output logic                                      m_tuser
);

	rxpc_pkg::cmd_t cmd;
	rxpc_pkg::sts_t sts;

	rxpc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	rxpc_datapath #(
		.ARRAY_SIZE (ARRAY_SIZE)
	) u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.cmd      (cmd),
		.sts      (sts)
	);

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> sts.out_free)
		else $error("result loaded over an untaken result");

	a_update_after_read: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.update |-> $past(cmd.freq_rd))
		else $error("frequency update without a preceding read");

	a_cmd_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.capture, cmd.step_start, cmd.freq_rd, cmd.update,
			cmd.out_load, cmd.clr_step}))
		else $error("conflicting datapath commands");

	a_bad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser) |-> (m_tdata[9:0] == 10'd0))
		else $error("bad range answer with nonzero count");

endmodule

`default_nettype wire
